// ===== src/insertion_sort_engine_defines.svh =====
// Assertion macros shared by the insertion sort engine.
`ifndef INSERTION_SORT_ENGINE_DEFINES_SVH
`define INSERTION_SORT_ENGINE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISE_ASSERT_SAME(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("insertion sort engine: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ISE_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("insertion sort engine: next-cycle check failed");

`endif

// ===== src/isort_pkg.sv =====
// Package with the shared constants and control types of the insertion sort engine.
`timescale 1ns / 1ps

package isort_pkg;

  localparam int unsigned ISORT_DEPTH     = 64;
  localparam int unsigned ISORT_KEY_WIDTH = 16;
  localparam int unsigned ISORT_ID_WIDTH  = 16;

  typedef struct packed {
    logic ins;
    logic shift;
  } isort_ctl_t;

endpackage

// ===== src/isort_cell.sv =====
// One cell of the sorting chain, holding a single record and its valid bit.
`timescale 1ns / 1ps

module isort_cell #(
  parameter int unsigned KEY_WIDTH = 16,
  parameter int unsigned ID_WIDTH  = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  isort_pkg::isort_ctl_t  ctl,
  input  logic [KEY_WIDTH-1:0]   new_key,
  input  logic [ID_WIDTH-1:0]    new_id,
  input  logic                   left_valid,
  input  logic                   left_take,
  input  logic [KEY_WIDTH-1:0]   left_key,
  input  logic [ID_WIDTH-1:0]    left_id,
  input  logic                   right_valid,
  input  logic [KEY_WIDTH-1:0]   right_key,
  input  logic [ID_WIDTH-1:0]    right_id,
  output logic                   take,
  output logic                   valid,
  output logic [KEY_WIDTH-1:0]   key,
  output logic [ID_WIDTH-1:0]    id
);
  import isort_pkg::*;

  // The new record belongs at or before this slot when the slot is empty
  // or holds a strictly greater key, which keeps equal keys in arrival order.
  assign take = !valid || (new_key < key);

  // An insertion grows the occupied run by one cell, so an empty cell fills
  // only when its left neighbor is occupied.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= right_valid;
    end else if (ctl.ins && take) begin
      valid <= valid || left_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      key <= right_key;
      id  <= right_id;
    end else if (ctl.ins && take) begin
      if (left_take) begin
        key <= left_key;
        id  <= left_id;
      end else begin
        key <= new_key;
        id  <= new_id;
      end
    end
  end

endmodule

// ===== src/insertion_sort_engine.sv =====
// Top level of the insertion sort engine: a chain of record cells and its control.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------------
//   record  | rec_valid, rec_stall | sort_key, payload_id, run_end
//   result  | res_valid, res_stall | sorted_key, sorted_id, run_last, overflow
//
// A record is inserted as soon as it is accepted, so records of a run are taken back to back.
// After the record marked run_end, the chain drains one result per cycle from its
// first cell while res_stall is low; rec_stall is high during the drain. A stalled
// result holds the chain. Reset empties the chain.
`timescale 1ns / 1ps

module insertion_sort_engine #(
  parameter int unsigned DEPTH     = isort_pkg::ISORT_DEPTH,
  parameter int unsigned KEY_WIDTH = isort_pkg::ISORT_KEY_WIDTH,
  parameter int unsigned ID_WIDTH  = isort_pkg::ISORT_ID_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rec_valid,
  output logic                 rec_stall,
  input  logic [KEY_WIDTH-1:0] sort_key,
  input  logic [ID_WIDTH-1:0]  payload_id,
  input  logic                 run_end,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [KEY_WIDTH-1:0] sorted_key,
  output logic [ID_WIDTH-1:0]  sorted_id,
  output logic                 run_last,
  output logic                 overflow
);
  import isort_pkg::*;

  `include "insertion_sort_engine_defines.svh"

  logic                 draining;
  logic                 draining_next;
  logic                 dropped;
  logic                 dropped_next;
  logic                 rec_acc;
  logic                 res_acc;
  logic                 full;
  isort_ctl_t           ctl;
  logic [DEPTH-1:0]     valid_vec;
  logic [DEPTH-1:0]     take_vec;
  logic [DEPTH-1:0]     valid_inc;
  logic [KEY_WIDTH-1:0] keys [DEPTH];
  logic [ID_WIDTH-1:0]  ids  [DEPTH];

  assign full      = valid_vec[DEPTH-1];
  assign rec_stall = draining;
  assign rec_acc   = rec_valid && !rec_stall;
  assign res_valid = draining;
  assign res_acc   = res_valid && !res_stall;
  assign ctl.ins   = rec_acc && !full;
  assign ctl.shift = res_acc;

  assign sorted_key = keys[0];
  assign sorted_id  = ids[0];
  assign run_last   = !valid_vec[1];
  assign overflow   = dropped;

  always_comb begin
    draining_next = draining;
    dropped_next  = dropped;
    if (rec_acc) begin
      if (full) begin
        dropped_next = 1'b1;
      end
      if (run_end) begin
        draining_next = 1'b1;
      end
    end
    if (res_acc && run_last) begin
      draining_next = 1'b0;
      dropped_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
      dropped  <= 1'b0;
    end else begin
      draining <= draining_next;
      dropped  <= dropped_next;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 left_valid;
    logic                 left_take;
    logic [KEY_WIDTH-1:0] left_key;
    logic [ID_WIDTH-1:0]  left_id;
    logic                 right_valid;
    logic [KEY_WIDTH-1:0] right_key;
    logic [ID_WIDTH-1:0]  right_id;

    if (i == 0) begin : g_first
      assign left_valid = 1'b1;
      assign left_take  = 1'b0;
      assign left_key   = '0;
      assign left_id    = '0;
    end else begin : g_inner_left
      assign left_valid = valid_vec[i-1];
      assign left_take  = take_vec[i-1];
      assign left_key   = keys[i-1];
      assign left_id    = ids[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_valid = 1'b0;
      assign right_key   = '0;
      assign right_id    = '0;
    end else begin : g_inner_right
      assign right_valid = valid_vec[i+1];
      assign right_key   = keys[i+1];
      assign right_id    = ids[i+1];
    end

    isort_cell #(
      .KEY_WIDTH(KEY_WIDTH),
      .ID_WIDTH (ID_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .new_key    (sort_key),
      .new_id     (payload_id),
      .left_valid (left_valid),
      .left_take  (left_take),
      .left_key   (left_key),
      .left_id    (left_id),
      .right_valid(right_valid),
      .right_key  (right_key),
      .right_id   (right_id),
      .take       (take_vec[i]),
      .valid      (valid_vec[i]),
      .key        (keys[i]),
      .id         (ids[i])
    );
  end

  // The occupied cells always form an unbroken run starting at the first cell.
  assign valid_inc = valid_vec + DEPTH'(1);

  `ISE_ASSERT_SAME(a_drain_has_data, draining, valid_vec[0])
  `ISE_ASSERT_SAME(a_cells_packed, 1'b1, (valid_inc & valid_vec) == '0)
  `ISE_ASSERT_NEXT(a_end_starts_drain, rec_acc && run_end, draining)
  `ISE_ASSERT_NEXT(a_last_ends_drain, res_acc && run_last,
                   !draining && !dropped && !valid_vec[0])

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the insertion sort engine with its own stable-sort predictor.
`timescale 1ns / 1ps

module tb;

  localparam int KW = isort_pkg::ISORT_KEY_WIDTH;
  localparam int IW = isort_pkg::ISORT_ID_WIDTH;
  localparam int DEPTH = isort_pkg::ISORT_DEPTH;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD = 150;
  localparam int QUIET_TAIL = 25;

  typedef struct {
    logic [KW-1:0] key;
    logic [IW-1:0] id;
    logic          last;
    bit            drain_first;
  } record_t;

  typedef struct {
    logic [KW-1:0] key;
    logic [IW-1:0] id;
    logic          last;
    logic          ovf;
  } sorted_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          rec_valid = 1'b0;
  logic          rec_stall;
  logic [KW-1:0] sort_key = '0;
  logic [IW-1:0] payload_id = '0;
  logic          run_end = 1'b0;
  logic          res_valid;
  logic          res_stall = 1'b0;
  logic [KW-1:0] sorted_key;
  logic [IW-1:0] sorted_id;
  logic          run_last;
  logic          overflow;

  record_t       pending_records[$];
  sorted_t       sorted_due[$];

  logic [KW-1:0] chain_key[DEPTH];
  logic [IW-1:0] chain_id[DEPTH];
  int            chain_fill = 0;
  bit            chain_dropped = 1'b0;

  bit            rec_took = 1'b0;
  int            records_taken = 0;
  int            results_seen = 0;
  int            runs_closed = 0;
  int            overflow_runs = 0;
  int            errors = 0;
  int            cycle_count = 0;

  int            send_gap = 0;
  int            recv_gap = 0;
  int            hold_left = 0;
  bit            hold_done = 1'b0;

  insertion_sort_engine uut (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (rec_valid),
    .rec_stall (rec_stall),
    .sort_key  (sort_key),
    .payload_id(payload_id),
    .run_end   (run_end),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .sorted_key(sorted_key),
    .sorted_id (sorted_id),
    .run_last  (run_last),
    .overflow  (overflow)
  );

  always #2 clk = ~clk;

  function automatic bit idle_allowed();
    return (pending_records.size() > QUIET_TAIL) && ((cycle_count / 256) % 3 != 2);
  endfunction

  // Inserts one record after all equal keys, or drops it when the store is full, and,
  // on the last record of a run, queues the whole stored run in ascending order.
  task automatic sort_record(logic [KW-1:0] key, logic [IW-1:0] id, logic last);
    int pos;
    sorted_t s;
    if (chain_fill >= DEPTH) begin
      chain_dropped = 1'b1;
    end else begin
      pos = chain_fill;
      while (pos > 0 && key < chain_key[pos-1]) begin
        chain_key[pos] = chain_key[pos-1];
        chain_id[pos] = chain_id[pos-1];
        pos--;
      end
      chain_key[pos] = key;
      chain_id[pos] = id;
      chain_fill++;
    end
    if (last) begin
      for (int k = 0; k < chain_fill; k++) begin
        s.key = chain_key[k];
        s.id = chain_id[k];
        s.last = (k == chain_fill - 1);
        s.ovf = chain_dropped;
        sorted_due.push_back(s);
      end
      runs_closed++;
      if (chain_dropped) overflow_runs++;
      chain_fill = 0;
      chain_dropped = 1'b0;
    end
  endtask

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic push_record(logic [KW-1:0] key, logic [IW-1:0] id, logic last,
                             bit drain_first);
    record_t r;
    r.key = key;
    r.id = id;
    r.last = last;
    r.drain_first = drain_first;
    pending_records.push_back(r);
  endtask

  task automatic add_run(int len, bit few_keys, bit drain_first);
    logic [KW-1:0] pool[3];
    for (int i = 0; i < 3; i++) pool[i] = KW'($urandom);
    for (int i = 0; i < len; i++) begin
      push_record(few_keys ? pool[$urandom_range(0, 2)] : KW'($urandom), IW'($urandom),
                  i == len - 1, drain_first && i == 0);
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (rec_valid && !rec_took) begin
      rec_valid <= 1'b1;
    end else if (send_gap > 0) begin
      rec_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_records.size() == 0) begin
      rec_valid <= 1'b0;
    end else if (pending_records[0].drain_first && sorted_due.size() != 0) begin
      rec_valid <= 1'b0;
    end else if (idle_allowed() && $urandom_range(0, 5) == 0) begin
      rec_valid <= 1'b0;
      send_gap <= $urandom_range(0, 2);
    end else begin
      rec_valid <= 1'b1;
      sort_key <= pending_records[0].key;
      payload_id <= pending_records[0].id;
      run_end <= pending_records[0].last;
      void'(pending_records.pop_front());
    end
  end

  // The long hold lands during a drain, so the sender is kept waiting.
  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && res_valid && results_seen >= 30) begin
      res_stall <= 1'b1;
      hold_left <= LONG_HOLD - 1;
      hold_done <= 1'b1;
    end else if (recv_gap > 0) begin
      res_stall <= 1'b1;
      recv_gap <= recv_gap - 1;
    end else if (idle_allowed() && $urandom_range(0, 4) == 0) begin
      res_stall <= 1'b1;
      recv_gap <= $urandom_range(0, 2);
    end else begin
      res_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    sorted_t want;
    if (rst) begin
      rec_took <= 1'b0;
    end else begin
      rec_took <= rec_valid && !rec_stall;
      if (rec_valid && !rec_stall) begin
        records_taken++;
        sort_record(sort_key, payload_id, run_end);
      end
      if (res_valid && !res_stall) begin
        results_seen++;
        if (sorted_due.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual key %0h id %0h last %b ovf %b",
                   $time, sorted_key, sorted_id, run_last, overflow);
          errors++;
        end else begin
          want = sorted_due.pop_front();
          compare_field("sorted_key", 64'(want.key), 64'(sorted_key));
          compare_field("sorted_id", 64'(want.id), 64'(sorted_id));
          compare_field("run_last", 64'(want.last), 64'(run_last));
          compare_field("overflow", 64'(want.ovf), 64'(overflow));
        end
      end
    end
  end

  initial begin
    push_record(16'h0000, 16'h0000, 1'b1, 1'b0);
    push_record(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    push_record(16'hFFFF, 16'h0001, 1'b0, 1'b0);
    push_record(16'h8000, 16'h0002, 1'b0, 1'b0);
    push_record(16'h0001, 16'h0003, 1'b0, 1'b0);
    push_record(16'h0000, 16'h0004, 1'b1, 1'b0);
    push_record(16'h1234, 16'hAAAA, 1'b0, 1'b0);
    push_record(16'h1234, 16'h5555, 1'b0, 1'b0);
    push_record(16'h0000, 16'h0100, 1'b0, 1'b0);
    push_record(16'h1234, 16'h0F0F, 1'b1, 1'b0);
    push_record(16'h0000, 16'h0001, 1'b0, 1'b0);
    push_record(16'h0000, 16'h0002, 1'b0, 1'b0);
    push_record(16'h7FFF, 16'h0003, 1'b0, 1'b0);
    push_record(16'hFFFF, 16'h0004, 1'b0, 1'b0);
    push_record(16'hFFFF, 16'h0005, 1'b1, 1'b0);

    // A run that exactly fills the store, then one that drops records including its last.
    add_run(DEPTH, 1'b0, 1'b1);
    add_run(DEPTH + 3, 1'b1, 1'b1);
    while (pending_records.size() < 215) begin
      add_run($urandom_range(1, 10), $urandom_range(0, 2) == 0, $urandom_range(0, 7) == 0);
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_records.size() != 0 || rec_valid) @(posedge clk);
    while (sorted_due.size() != 0) @(posedge clk);
    repeat (DEPTH + 16) @(posedge clk);

    if (sorted_due.size() != 0) begin
      $display("%0t: %0d sorted items never arrived", $time, sorted_due.size());
      errors++;
    end
    $display("Sorted %0d records in %0d runs (%0d with dropped records), checked %0d items.",
             records_taken, runs_closed, overflow_runs, results_seen);
    $display("Runs ranged from a single record to past a full store, under random stalls.");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/isort_pkg.sv
src/isort_cell.sv
src/insertion_sort_engine.sv
sim/tb.sv
